### rtl/pvqm_pkg.sv
// package for the proposal value queue manager
// request codes, default sizes and the result item layout; no dependencies
`default_nettype none
package pvqm_pkg;
    localparam int QueueDepth = 16;
    localparam int KeyWidth   = 32;
    localparam int OutKeyWidth = 32;

    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_GET     = 3'd1;
    localparam logic [2:0] REQ_QUERY   = 3'd2;
    localparam logic [2:0] REQ_CLOSE   = 3'd3;
    localparam logic [2:0] REQ_REQUEUE = 3'd4;

    // last member is the lowest bit: hit in bit 0
    typedef struct packed {
        logic                   overflow;
        logic                   is_noop;
        logic [OutKeyWidth-1:0] value_out;
        logic                   hit;
    } result_t;
endpackage
`default_nettype wire

### rtl/pvqm_queue.sv
// one key queue in a memory, with a registered read port and a loadable count
// uses pvqm_pkg; driven by the top-level sequencer
`default_nettype none
module pvqm_queue #(
    parameter int QUEUE_DEPTH = pvqm_pkg::QueueDepth,
    parameter int KEY_WIDTH   = pvqm_pkg::KeyWidth,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // memory access
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [KEY_WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [KEY_WIDTH-1:0] rd_data,
    // count update
    input  wire logic                 cnt_load,
    input  wire logic [CW-1:0]        cnt_value,
    output logic      [CW-1:0]        count
);
    logic [KEY_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cnt_load)
        begin
            count_reg <= cnt_value;
        end
    end

    assign count = count_reg;
endmodule
`default_nettype wire

### rtl/proposal_value_queue_manager_unit.sv
// top level of the proposal value queue manager: sequencer and two queues
// uses pvqm_pkg and pvqm_queue
// One request item at a time. Each queue sits in a one-port-write, one-port-read
// memory with registered read data, and a small sequencer walks it entry by entry
// with a read state and a write state per entry. Get next shifts the queue it pops;
// query and close sweep pending then proposed; requeue adds up to two front-insert
// shifts of pending. The longest request is a requeue that finds the key in both
// queues. The sequencer returns to idle before it can take the next item. The result
// item sits in an output register, so the next request is accepted while it waits;
// the sequencer holds its last state only while an earlier result is still untaken.
`default_nettype none
module proposal_value_queue_manager_unit #(
    parameter int QUEUE_DEPTH = pvqm_pkg::QueueDepth,
    parameter int KEY_WIDTH   = pvqm_pkg::KeyWidth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: req_type[2:0], value_key[34:3], fill_holes[35], zero pad [39:36]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: hit[0], value_out[32:1], is_noop[33], overflow[34], zero pad [39:35]
    output logic      [39:0] m_tdata
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
    localparam int OW = pvqm_pkg::OutKeyWidth;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_SHRD  = 10'b0000000100,  // shift: read
        S_SHWR  = 10'b0000001000,  // shift: write
        S_SCRD  = 10'b0000010000,  // compaction scan: issue read
        S_SCWR  = 10'b0000100000,  // compaction scan: compare and write
        S_INS   = 10'b0001000000,  // requeue front inserts
        S_FRD   = 10'b0010000000,  // get-next: read front
        S_FWR   = 10'b0100000000,  // get-next: append front
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic repro_reg;
    logic [2:0] req_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic fill_reg;
    logic sel_reg;                // queue under work: 0 pending, 1 proposed
    logic [CW-1:0] ri_reg, wi_reg;
    logic fa_reg, fb_reg;         // found in pending / proposed
    logic ins_b_reg;              // proposed copy insert still to do
    logic dir_up_reg;             // shift direction: 1 pops front, 0 opens front
    logic [KEY_WIDTH-1:0] hold_reg;
    logic after_pop_reg;          // get-next: append hold after the pop
    logic dst_reg;                // append destination queue
    logic rot_reg;
    pvqm_pkg::result_t res_reg;
    pvqm_pkg::result_t out_reg;
    logic out_v_reg;

    logic [1:0] wr_en;
    logic [AW-1:0] wr_addr [2];
    logic [KEY_WIDTH-1:0] wr_data [2];
    logic [AW-1:0] rd_addr [2];
    logic [KEY_WIDTH-1:0] rd_data [2];
    logic [1:0] cnt_load;
    logic [CW-1:0] cnt_value [2];
    logic [CW-1:0] count [2];

    for (genvar q = 0; q < 2; q++)
    begin : g_q
        pvqm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_q (
            .clk(clk), .rst_n(rst_n),
            .wr_en(wr_en[q]), .wr_addr(wr_addr[q]), .wr_data(wr_data[q]),
            .rd_addr(rd_addr[q]), .rd_data(rd_data[q]),
            .cnt_load(cnt_load[q]), .cnt_value(cnt_value[q]), .count(count[q])
        );
    end

    logic [KEY_WIDTH-1:0] in_key;
    logic [CW-1:0] cur_cnt;
    logic [KEY_WIDTH-1:0] cur_rd;
    assign in_key  = KEY_WIDTH'(s_tdata[34:3]);
    assign cur_cnt = sel_reg ? count[1] : count[0];
    assign cur_rd  = sel_reg ? rd_data[1] : rd_data[0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repro_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            repro_reg <= cfg_wdata;
        end
    end

    // memory control from the sequencer state
    always_comb
    begin
        wr_en = '0;
        cnt_load = '0;
        for (int q = 0; q < 2; q++)
        begin
            wr_addr[q] = wi_reg[AW-1:0];
            wr_data[q] = hold_reg;
            rd_addr[q] = ri_reg[AW-1:0];
            cnt_value[q] = wi_reg;
        end
        unique case (state_reg)
            S_DISP:
            begin
                if (req_reg == pvqm_pkg::REQ_ENQUEUE && count[0] != FULL)
                begin
                    wr_en[0] = 1'b1;
                    wr_addr[0] = count[0][AW-1:0];
                    wr_data[0] = key_reg;
                    cnt_load[0] = 1'b1;
                    cnt_value[0] = count[0] + 1'b1;
                end
            end
            S_FWR:
            begin
                if (count[dst_reg] != FULL)
                begin
                    wr_en[dst_reg] = 1'b1;
                    wr_addr[dst_reg] = count[dst_reg][AW-1:0];
                    wr_data[dst_reg] = hold_reg;
                    cnt_load[dst_reg] = 1'b1;
                    cnt_value[dst_reg] = count[dst_reg] + 1'b1;
                end
            end
            S_SHWR:
            begin
                wr_en[sel_reg] = 1'b1;
                wr_data[sel_reg] = cur_rd;
            end
            S_SCWR:
            begin
                if (cur_rd != key_reg && req_reg != pvqm_pkg::REQ_QUERY)
                begin
                    wr_en[sel_reg] = 1'b1;
                    wr_data[sel_reg] = cur_rd;
                end
            end
            S_INS:
            begin
                wr_en[0] = 1'b1;
                wr_addr[0] = '0;
                wr_data[0] = key_reg;
            end
            default:
            begin
            end
        endcase
        // count loads at the end of passes are handled here too
        if (state_reg == S_SCRD && ri_reg == cur_cnt && req_reg != pvqm_pkg::REQ_QUERY)
        begin
            cnt_load[sel_reg] = 1'b1;
            cnt_value[sel_reg] = wi_reg;
        end
        if (state_reg == S_SHRD && dir_up_reg && ri_reg == cur_cnt)
        begin
            cnt_load[sel_reg] = 1'b1;
            cnt_value[sel_reg] = cur_cnt - 1'b1;
        end
        if (state_reg == S_SHRD && !dir_up_reg && wi_reg == '0)
        begin
            cnt_load[0] = 1'b1;
            cnt_value[0] = count[0] + 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_v_reg || m_tready))
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    logic do_ins;
    always_comb
    begin
        state_next = state_reg;
        do_ins = (fb_reg || fa_reg) && count[0] != FULL;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid && s_tready) state_next = S_DISP;
            S_DISP:
            begin
                unique case (req_reg)
                    pvqm_pkg::REQ_ENQUEUE: state_next = S_DONE;
                    pvqm_pkg::REQ_GET:
                        state_next = (count[0] != '0 ||
                                      (count[1] != '0 && repro_reg)) ? S_FRD : S_DONE;
                    pvqm_pkg::REQ_QUERY,
                    pvqm_pkg::REQ_CLOSE,
                    pvqm_pkg::REQ_REQUEUE: state_next = S_SCRD;
                    default: state_next = S_DONE;
                endcase
            end
            S_FRD:   state_next = S_SHRD;
            S_SHRD:
            begin
                if (dir_up_reg)
                    state_next = (ri_reg == cur_cnt) ? (after_pop_reg ? S_FWR : S_DONE)
                                                     : S_SHWR;
                else
                    state_next = (wi_reg == '0) ? S_INS : S_SHWR;
            end
            S_SHWR:  state_next = S_SHRD;
            S_FWR:   state_next = S_DONE;
            S_SCRD:
            begin
                if (ri_reg == cur_cnt)
                begin
                    if (!sel_reg)
                        state_next = S_SCRD;
                    else if (req_reg == pvqm_pkg::REQ_REQUEUE && (fb_reg || fa_reg))
                        state_next = do_ins ? S_SHRD : S_DONE;
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_SCWR;
            end
            S_SCWR:  state_next = S_SCRD;
            S_INS:
            begin
                if (ins_b_reg && fa_reg)
                    state_next = (count[0] != FULL) ? S_SHRD : S_DONE;
                else
                    state_next = S_DONE;
            end
            // hold the finished result until the output register is free
            S_DONE:  state_next = (!out_v_reg || m_tready) ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg  <= s_tdata[2:0];
                key_reg  <= in_key;
                fill_reg <= s_tdata[35];
                res_reg  <= '0;
                fa_reg   <= 1'b0;
                fb_reg   <= 1'b0;
                ri_reg   <= '0;
                wi_reg   <= '0;
                sel_reg  <= 1'b0;
            end
            S_DISP:
            begin
                unique case (req_reg)
                    pvqm_pkg::REQ_ENQUEUE:
                    begin
                        res_reg.hit      <= (count[0] != FULL);
                        res_reg.overflow <= (count[0] == FULL);
                    end
                    pvqm_pkg::REQ_GET:
                    begin
                        rot_reg <= (count[0] == '0);
                        sel_reg <= (count[0] == '0);
                        dst_reg <= 1'b1;
                        ri_reg  <= '0;
                        if (count[0] == '0 && !(count[1] != '0 && repro_reg) && fill_reg)
                        begin
                            res_reg.hit     <= 1'b1;
                            res_reg.is_noop <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FRD:
            begin
                // read of slot 0 issued; shift pass starts at entry 1
                dir_up_reg    <= 1'b1;
                after_pop_reg <= 1'b1;
                ri_reg        <= CW'(1);
                wi_reg        <= '0;
            end
            S_SHRD:
            begin
                // front key lands during the first shift read
                if (dir_up_reg && ri_reg == CW'(1) && wi_reg == '0)
                    hold_reg <= cur_rd;
                if (dir_up_reg && ri_reg != cur_cnt)
                    ri_reg <= ri_reg + 1'b1;
                if (!dir_up_reg && wi_reg != '0)
                    ri_reg <= wi_reg - CW'(2);
            end
            S_SHWR:
            begin
                if (dir_up_reg)
                    wi_reg <= wi_reg + 1'b1;
                else
                    wi_reg <= wi_reg - 1'b1;
            end
            S_FWR:
            begin
                res_reg.hit       <= 1'b1;
                res_reg.value_out <= OW'(hold_reg);
                res_reg.overflow  <= (count[1] == FULL) && !rot_reg;
            end
            S_SCRD:
            begin
                if (ri_reg == cur_cnt)
                begin
                    if (!sel_reg)
                    begin
                        sel_reg <= 1'b1;
                        ri_reg  <= '0;
                        wi_reg  <= '0;
                    end
                    else
                    begin
                        res_reg.hit <= fa_reg || fb_reg;
                        ins_b_reg   <= fb_reg;
                        if (req_reg == pvqm_pkg::REQ_REQUEUE && (fa_reg || fb_reg))
                        begin
                            res_reg.overflow <= (count[0] == FULL) ||
                                (fa_reg && fb_reg && count[0] == FULL - 1'b1);
                            sel_reg    <= 1'b0;
                            dir_up_reg <= 1'b0;
                            wi_reg     <= count[0];
                            ri_reg     <= count[0] - 1'b1;
                        end
                    end
                end
                else
                    ri_reg <= ri_reg + 1'b1;
            end
            S_SCWR:
            begin
                if (cur_rd == key_reg)
                begin
                    if (sel_reg) fb_reg <= 1'b1;
                    else         fa_reg <= 1'b1;
                end
                else
                    wi_reg <= wi_reg + 1'b1;
            end
            S_INS:
            begin
                if (ins_b_reg && fa_reg)
                begin
                    ins_b_reg <= 1'b0;
                    wi_reg    <= count[0];
                    ri_reg    <= count[0] - 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_v_reg || m_tready)
                    out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/pvqm_checker.sv
// port-level checker for the proposal value queue manager
// bound to proposal_value_queue_manager_unit; no package use
`default_nettype none
module pvqm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    // the block is busy right after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("input ready while busy");
    // a no-op answer always carries hit and a zero key
    a_noop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[0] && m_tdata[32:1] == 32'd0))
        else $error("bad no-op result");
    // padding stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:35] == 5'd0)) else $error("pad bits set");
    // an accepted item gives no result in the cycle after it is taken, when no result is pending
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid) else $error("result too early");
    // a held result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
endmodule

bind proposal_value_queue_manager_unit pvqm_checker u_pvqm_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
